@@ rtl/rlfc_pkg.sv @@
// Shared types, codes and constants for the relay link frame controller.
package rlfc_pkg;

	localparam logic [7:0] HDR0_BYTE    = 8'hA0;
	localparam logic [7:0] HDR1_BYTE    = 8'h04;
	localparam logic [7:0] TRAILER_BYTE = 8'hA1;

	localparam logic [15:0] DEBOUNCE_RESET = 16'd70;
	localparam logic [15:0] SETTLE_RESET   = 16'd500;
	localparam logic [15:0] SINCE_MAX      = 16'hFFFF;
	localparam logic [2:0]  PUSH_MAX       = 3'd4;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SETTLE   = 2'd1;

	localparam logic [2:0] FUNC_RX     = 3'd0;
	localparam logic [2:0] FUNC_TICK   = 3'd1;
	localparam logic [2:0] FUNC_SET1   = 3'd2;
	localparam logic [2:0] FUNC_SET2   = 3'd3;
	localparam logic [2:0] FUNC_RESEND = 3'd4;
	localparam logic [2:0] FUNC_STATUS = 3'd5;

	localparam logic [1:0] OUT_TX     = 2'd0;
	localparam logic [1:0] OUT_AP     = 2'd1;
	localparam logic [1:0] OUT_STATUS = 2'd2;

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_PAYLOAD,
		PH_TRAILER,
		PH_DISCARD
	} rlfc_phase_t;

	typedef enum logic [1:0] {
		DK_FRAME,
		DK_AP,
		DK_STATUS
	} rlfc_dkind_t;

	// One queued response: a four-beat frame, an AP request or a status beat.
	typedef struct packed {
		rlfc_dkind_t kind;
		logic        ap;
		logic [1:0]  relay;
	} rlfc_desc_t;

endpackage

@@ rtl/rlfc_core.sv @@
// Input register, frame parser, button logic and relay state update.
module rlfc_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [2:0]                      func,
	input  logic [7:0]                      rx_byte,
	input  logic                            relay_select,
	input  logic                            relay_on,
	input  logic                            relay0_level,
	input  logic                            relay1_level,
	input  logic                            cfg_we,
	input  logic [rlfc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rlfc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                            push,
	output rlfc_pkg::rlfc_desc_t            push_desc,
	input  logic                            q_full
);
	import rlfc_pkg::*;

	logic        valid_s1;
	logic [2:0]  func_s1;
	logic [7:0]  rx_s1;
	logic        sel_s1, on_s1, r0_s1, r1_s1;

	logic [15:0] debounce_q, settle_q;
	rlfc_phase_t phase_q, phase_d;
	logic [1:0]  held_q, held_d;
	logic [1:0]  relay_q, relay_d;
	logic [2:0]  count_q, count_d;
	logic [15:0] since_q, since_d;

	logic        push_req, commit;
	logic [15:0] since_inc;
	logic [1:0]  mask;
	rlfc_desc_t  desc;

	assign commit   = valid_s1 && !(push_req && q_full);
	assign in_stall = valid_s1 && !commit;
	assign push     = valid_s1 && push_req && !q_full;
	assign push_desc = desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1 <= func;
			rx_s1   <= rx_byte;
			sel_s1  <= relay_select;
			on_s1   <= relay_on;
			r0_s1   <= relay0_level;
			r1_s1   <= relay1_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			settle_q   <= SETTLE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_data;
				REG_SETTLE:   settle_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign since_inc = (since_q == SINCE_MAX) ? since_q : since_q + 16'd1;
	assign mask      = sel_s1 ? 2'b10 : 2'b01;

	always_comb begin
		phase_d  = phase_q;
		held_d   = held_q;
		relay_d  = relay_q;
		count_d  = count_q;
		since_d  = since_q;
		push_req = 1'b0;
		desc.kind = DK_FRAME;
		desc.ap   = 1'b0;
		case (func_s1)
			FUNC_RX: begin
				case (phase_q)
					PH_HDR0:    phase_d = (rx_s1 == HDR0_BYTE) ? PH_HDR1 : PH_DISCARD;
					PH_HDR1:    phase_d = (rx_s1 == HDR1_BYTE) ? PH_PAYLOAD : PH_DISCARD;
					PH_PAYLOAD: begin
						held_d  = rx_s1[1:0];
						phase_d = PH_TRAILER;
					end
					PH_TRAILER: begin
						if (rx_s1 == TRAILER_BYTE) begin
							phase_d = PH_HDR0;
							// a new payload adopts; a repeat past the debounce time counts as a push
							if (held_q != relay_q) begin
								relay_d = held_q;
							end else if (since_q >= debounce_q) begin
								since_d = '0;
								if (count_q < PUSH_MAX) count_d = count_q + 3'd1;
							end
						end else begin
							phase_d = PH_DISCARD;
						end
					end
					default: begin
						if (rx_s1 == TRAILER_BYTE) phase_d = PH_HDR0;
					end
				endcase
			end
			FUNC_TICK: begin
				since_d = since_inc;
				if (count_q != 3'd0 && since_inc >= settle_q) begin
					count_d  = '0;
					push_req = 1'b1;
					case (count_q)
						3'd1:    relay_d = relay_q ^ 2'b10;
						3'd2:    relay_d = relay_q ^ 2'b01;
						3'd3: begin
							desc.kind = DK_AP;
							desc.ap   = 1'b1;
						end
						default: desc.kind = DK_AP;
					endcase
				end
			end
			FUNC_SET1: begin
				relay_d  = on_s1 ? (relay_q | mask) : (relay_q & ~mask);
				push_req = 1'b1;
			end
			FUNC_SET2: begin
				relay_d  = {r0_s1, r1_s1};
				push_req = 1'b1;
			end
			FUNC_RESEND: push_req = 1'b1;
			FUNC_STATUS: begin
				push_req  = 1'b1;
				desc.kind = DK_STATUS;
			end
			default: ;
		endcase
		desc.relay = relay_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			held_q  <= '0;
			relay_q <= '0;
			count_q <= '0;
			since_q <= '0;
		end else if (commit) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			relay_q <= relay_d;
			count_q <= count_d;
			since_q <= since_d;
		end
	end

endmodule

@@ rtl/rlfc_outq.sv @@
// Two-entry response queue and beat serializer for the output channel.
module rlfc_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rlfc_pkg::rlfc_desc_t push_desc,
	output logic                 q_full,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           out_kind,
	output logic [7:0]           tx_byte,
	output logic                 ap_enable,
	output logic [1:0]           relay_bits,
	output logic                 last
);
	import rlfc_pkg::*;

	rlfc_desc_t entry_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] fill_q;
	logic [1:0] beat_q;
	rlfc_desc_t head;
	logic       take, pop;

	assign head      = entry_q[rptr_q];
	assign q_full    = (fill_q == 2'd2);
	assign out_valid = (fill_q != 2'd0);
	assign take      = out_valid && !out_stall;
	assign pop       = take && last;

	always_comb begin
		out_kind   = OUT_TX;
		tx_byte    = '0;
		ap_enable  = 1'b0;
		relay_bits = head.relay;
		last       = 1'b1;
		case (head.kind)
			DK_FRAME: begin
				last = (beat_q == 2'd3);
				case (beat_q)
					2'd0:    tx_byte = HDR0_BYTE;
					2'd1:    tx_byte = HDR1_BYTE;
					2'd2:    tx_byte = {6'd0, head.relay};
					default: tx_byte = TRAILER_BYTE;
				endcase
			end
			DK_AP: begin
				out_kind  = OUT_AP;
				ap_enable = head.ap;
			end
			default: out_kind = OUT_STATUS;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= '0;
			beat_q <= '0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: ;
			endcase
			// advance through frame beats, restart on the next entry
			if (pop)       beat_q <= '0;
			else if (take) beat_q <= beat_q + 2'd1;
		end
	end

endmodule

@@ rtl/relay_link_frame_controller.sv @@
// Top level of the relay link frame controller.
// Every input beat (rx byte, tick or host command) goes through one input register and
// is resolved combinationally from that register, so a new beat is taken every cycle while the response
// queue has room. Responses leave as beats: a frame is four beats (A0, 04, relay state,
// A1), an access point request or a status report is one beat, and the final beat of
// each response has last set. Output drain sets the sustained rate of inputs that send a
// response; quiet inputs put no beats in the queue. A two-entry response queue decouples
// the two sides, so input is stalled only when it is full and the registered beat needs
// a response. Configuration writes take effect at the edge on which cfg_we is high.
module relay_link_frame_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [2:0]                      func,
	input  logic [7:0]                      rx_byte,
	input  logic                            relay_select,
	input  logic                            relay_on,
	input  logic                            relay0_level,
	input  logic                            relay1_level,
	input  logic                            cfg_we,
	input  logic [rlfc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rlfc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      out_kind,
	output logic [7:0]                      tx_byte,
	output logic                            ap_enable,
	output logic [1:0]                      relay_bits,
	output logic                            last
);
	import rlfc_pkg::*;

	logic       push, q_full;
	rlfc_desc_t push_desc;

	rlfc_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.rx_byte      (rx_byte),
		.relay_select (relay_select),
		.relay_on     (relay_on),
		.relay0_level (relay0_level),
		.relay1_level (relay1_level),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.push_desc    (push_desc),
		.q_full       (q_full)
	);

	rlfc_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.q_full     (q_full),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_kind   (out_kind),
		.tx_byte    (tx_byte),
		.ap_enable  (ap_enable),
		.relay_bits (relay_bits),
		.last       (last)
	);

endmodule

@@ rtl/rlfc_checker.sv @@
// Port-level checks for the relay link frame controller, bound to the top level.
module rlfc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] out_kind,
	input logic [7:0] tx_byte,
	input logic       last
);
	import rlfc_pkg::*;

	// hold a stalled output beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(out_kind)
		&& $stable(last))
		else $error("stalled output beat changed");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != OUT_TX |-> last)
		else $error("request or status beat without last");

	a_trailer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == OUT_TX |-> (last == (tx_byte == TRAILER_BYTE)))
		else $error("frame trailer and last disagree");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_kind == OUT_TX || out_kind == OUT_AP || out_kind == OUT_STATUS))
		else $error("unknown output kind");

endmodule

bind relay_link_frame_controller rlfc_checker u_rlfc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_kind  (out_kind),
	.tx_byte   (tx_byte),
	.last      (last)
);
